>>> hdl/rwtf_pkg.sv
// Shared types and constants for the raycaster wall texel fetch block.
package rwtf_pkg;

  // Field widths
  localparam int SCREEN_COORD_BITS = 11;
  localparam int MAX_TEX_LOG2      = 6;
  localparam int COLOR_W           = 24;
  localparam int ADDR_IN_W         = 12;
  localparam int WALL_W            = 16;
  localparam int SLICE_W           = 16;
  localparam int SCREEN_H_W        = 12;
  localparam int TEX_LOG2_W        = 3;

  // |row - height/2 + slice/2| always fits this many bits
  localparam int NUM_MAG_W =
    $clog2((1 << SCREEN_COORD_BITS) + (1 << (SLICE_W - 1)));

  localparam logic [COLOR_W-1:0] HALF_MASK = 24'd8355711;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SCREEN_H_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_SIZE_LOG2 = 1'd1;
  localparam logic [SCREEN_H_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [TEX_LOG2_W-1:0] TEX_SIZE_LOG2_RST = 3'd6;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // Wall faces, also the texture slot numbers
  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  typedef struct packed {
    logic                         req_type;
    logic [1:0]                   tex_select;
    logic [ADDR_IN_W-1:0]         texel_addr;
    logic [COLOR_W-1:0]           texel_color;
    logic                         hit_side;
    logic                         dir_x_negative;
    logic                         dir_y_positive;
    logic [WALL_W-1:0]            wall_x_frac;
    logic [SLICE_W-1:0]           slice_height;
    logic [SCREEN_COORD_BITS-1:0] pixel_row;
    logic [SCREEN_COORD_BITS-1:0] pixel_column;
  } in_item_t;

  typedef struct packed {
    logic [SCREEN_COORD_BITS-1:0] out_row;
    logic [SCREEN_COORD_BITS-1:0] out_column;
    logic [COLOR_W-1:0]           pixel_color;
  } out_item_t;

endpackage

>>> hdl/rwtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwtf_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/raycast_wall_texel_fetch_core.sv
// Top level of the raycaster wall texel fetch: texture store and pixel pipeline.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to core   | in_valid_i / in_stall_o   | in_item_i  (load or draw)
//  out     | from core | out_valid_o / out_stall_i | out_item_o (shaded pixel)
//  cfg     | to core   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per clock while the output is not stalled. A draw result that is not
// black passes the entry register, NStg divider stages, the RAM read register and
// the output register, whatever the texture size register; NStg = ceil((NUM_MAG_W
// + MaxTexLog2)/2) comes from the restoring divider, two quotient bits per stage.
// Reset clears valid bits and sets config registers to their reset values; the texture store is not cleared.
// A stall on a valid output freezes the whole pipeline, RAM read register included,
// and is passed straight back to the input as in_stall_o.
module raycast_wall_texel_fetch_core
  import rwtf_pkg::*;
#(
  parameter int MaxTexLog2 = MAX_TEX_LOG2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int LgW     = $clog2(MaxTexLog2 + 1);
  localparam int SlotW   = 2 * MaxTexLog2;          // texels per texture, log2
  localparam int AddrW   = SlotW + 2;               // whole store
  localparam int Depth   = 4 << SlotW;
  localparam int NumW    = NUM_MAG_W + 1;           // signed numerator
  localparam int DivW    = NUM_MAG_W + MaxTexLog2;  // dividend |num| << MaxTexLog2
  localparam int NStg    = (DivW + 1) / 2;          // two bits per stage
  localparam int DivPadW = 2 * NStg;

  // Pipeline word through the divider stages
  typedef struct packed {
    logic                         is_load;
    logic [1:0]                   face;       // texture slot (tex_select on loads)
    logic [MaxTexLog2-1:0]        tx;
    logic [SlotW-1:0]             ld_addr;
    logic [COLOR_W-1:0]           ld_color;
    logic [SCREEN_COORD_BITS-1:0] row;
    logic [SCREEN_COORD_BITS-1:0] col;
    logic                         neg;        // numerator below zero
    logic [SLICE_W-1:0]           divisor;
    logic [SLICE_W-1:0]           rem;
    logic [DivPadW-1:0]           dvd;
    logic [MaxTexLog2-1:0]        quo;        // low quotient bits only
  } dstg_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SCREEN_H_W-1:0] screen_height_q;
  logic [TEX_LOG2_W-1:0] tex_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= SCREEN_HEIGHT_RST;
      tex_log2_q      <= TEX_SIZE_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i;
        CFG_TEX_SIZE_LOG2: tex_log2_q      <= cfg_wdata_i[TEX_LOG2_W-1:0];
      endcase
    end
  end

  // Effective texture size, saturated to 1..MaxTexLog2
  logic [LgW-1:0]        lg;
  logic [MaxTexLog2-1:0] lg_mask;

  always_comb begin
    if (tex_log2_q == '0) begin
      lg = LgW'(1);
    end else if (int'(tex_log2_q) > MaxTexLog2) begin
      lg = LgW'(MaxTexLog2);
    end else begin
      lg = LgW'(tex_log2_q);
    end
    lg_mask = ~({MaxTexLog2{1'b1}} << lg);
  end

  // ---------------------------------------------------------------------------
  // Global advance: everything moves unless a finished pixel is held
  // ---------------------------------------------------------------------------
  logic      pipe_en;
  logic      out_valid_q;
  out_item_t out_q;

  assign pipe_en    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~pipe_en;

  // ---------------------------------------------------------------------------
  // Entry stage: face, texture x, signed numerator
  // ---------------------------------------------------------------------------
  logic [NStg:0] v_q;
  dstg_t         p_q [NStg+1];
  dstg_t         p_d [NStg+1];

  logic [1:0]            face_in;
  logic [4:0]            tx_shamt;
  logic [WALL_W-1:0]     wx_sh;
  logic [MaxTexLog2-1:0] tx_in;
  logic [NumW-1:0]       num;
  logic [NUM_MAG_W-1:0]  mag;
  logic [SLICE_W-1:0]    lh_nz;

  always_comb begin
    if (in_item_i.hit_side) begin
      face_in = in_item_i.dir_y_positive ? FACE_SOUTH : FACE_NORTH;
    end else begin
      face_in = in_item_i.dir_x_negative ? FACE_WEST : FACE_EAST;
    end

    // (wall_x * size) >> 16, mirrored on south and west faces
    tx_shamt = 5'(WALL_W) - 5'(lg);
    wx_sh    = in_item_i.wall_x_frac >> tx_shamt;
    tx_in    = wx_sh[MaxTexLog2-1:0];
    if (face_in == FACE_WEST || face_in == FACE_SOUTH) begin
      tx_in = lg_mask & ~tx_in;
    end

    lh_nz = (in_item_i.slice_height == '0) ? SLICE_W'(1) : in_item_i.slice_height;
    num   = NumW'(in_item_i.pixel_row) + NumW'(in_item_i.slice_height >> 1)
          - NumW'(screen_height_q >> 1);
    mag   = num[NumW-1] ? NUM_MAG_W'(-num) : num[NUM_MAG_W-1:0];

    p_d[0].is_load  = (in_item_i.req_type == REQ_LOAD);
    p_d[0].face     = (in_item_i.req_type == REQ_LOAD) ? in_item_i.tex_select : face_in;
    p_d[0].tx       = tx_in;
    p_d[0].ld_addr  = SlotW'(in_item_i.texel_addr);
    p_d[0].ld_color = in_item_i.texel_color;
    p_d[0].row      = in_item_i.pixel_row;
    p_d[0].col      = in_item_i.pixel_column;
    p_d[0].neg      = num[NumW-1];
    p_d[0].divisor  = lh_nz;
    p_d[0].rem      = '0;
    p_d[0].dvd      = DivPadW'({mag, {MaxTexLog2{1'b0}}});
    p_d[0].quo      = '0;
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: |num| * 2^MaxTexLog2 / slice_height, two bits a stage.
  // floor(num*2^lg / lh) is the signed floor quotient shifted right by
  // MaxTexLog2 - lg, so one fixed-width divide serves every texture size.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NStg; k++) begin : g_div
    always_comb begin
      logic [SLICE_W:0] trial;
      p_d[k+1] = p_q[k];
      for (int s = 0; s < 2; s++) begin
        trial        = {p_d[k+1].rem, p_d[k+1].dvd[DivPadW-1]};
        p_d[k+1].dvd = p_d[k+1].dvd << 1;
        if (trial >= {1'b0, p_d[k+1].divisor}) begin
          p_d[k+1].rem = SLICE_W'(trial - {1'b0, p_d[k+1].divisor});
          p_d[k+1].quo = MaxTexLog2'({p_d[k+1].quo, 1'b1});
        end else begin
          p_d[k+1].rem = trial[SLICE_W-1:0];
          p_d[k+1].quo = MaxTexLog2'({p_d[k+1].quo, 1'b0});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_en) begin
      v_q <= {v_q[NStg-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i <= NStg; i++) begin
        p_q[i] <= p_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Store access: floor-correct the quotient, form the texel address, and
  // either write a load or read a draw, in item order
  // ---------------------------------------------------------------------------
  logic [MaxTexLog2-1:0] qf;
  logic [LgW-1:0]        ty_shamt;
  logic [MaxTexLog2-1:0] ty;
  logic [SlotW-1:0]      idx;
  logic [AddrW-1:0]      ram_addr;
  logic                  ram_we;
  logic                  ram_re;
  logic [COLOR_W-1:0]    ram_rdata;

  always_comb begin
    // negative numerator: -(q + (rem != 0)) == ~q + (rem == 0)
    if (p_q[NStg].neg) begin
      qf = ~p_q[NStg].quo + MaxTexLog2'(p_q[NStg].rem == '0);
    end else begin
      qf = p_q[NStg].quo;
    end
    ty_shamt = LgW'(MaxTexLog2) - lg;
    ty       = qf >> ty_shamt;
    idx      = (SlotW'(ty) << lg) | SlotW'(p_q[NStg].tx);
    ram_addr = {p_q[NStg].face, p_q[NStg].is_load ? p_q[NStg].ld_addr : idx};
  end

  assign ram_we = pipe_en & v_q[NStg] &  p_q[NStg].is_load;
  assign ram_re = pipe_en & v_q[NStg] & ~p_q[NStg].is_load;

  rwtf_ram #(
    .Width (COLOR_W),
    .Depth (Depth)
  ) u_tex_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (p_q[NStg].ld_color),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Side info riding alongside the RAM read
  logic                         r_valid_q;
  logic [SCREEN_COORD_BITS-1:0] r_row_q;
  logic [SCREEN_COORD_BITS-1:0] r_col_q;
  logic                         r_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (pipe_en) begin
      r_valid_q <= v_q[NStg] & ~p_q[NStg].is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r_row_q  <= p_q[NStg].row;
      r_col_q  <= p_q[NStg].col;
      r_half_q <= (p_q[NStg].face == FACE_NORTH) || (p_q[NStg].face == FACE_EAST);
    end
  end

  // ---------------------------------------------------------------------------
  // Shading and output register; black texels are dropped
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] shade;

  assign shade = r_half_q ? ((ram_rdata >> 1) & HALF_MASK) : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= r_valid_q && (shade != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q.out_row     <= r_row_q;
      out_q.out_column  <= r_col_q;
      out_q.pixel_color <= shade;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_black_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.pixel_color != '0))
    else $error("black pixel presented");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a held output");

  a_one_ram_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(v_q) && $stable(r_valid_q)))
    else $error("pipeline moved while frozen");

endmodule
